[rtl/fpa_pkg.sv]
// shared types and constants for the binary32 adder pipeline
`default_nettype none
package fpa_pkg;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [7:0]  ExpMax     = 8'hFF;

  // stage 1 -> stage 2: aligned significands and special-case result
  typedef struct packed {
    logic        valid;
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic        sub;
    logic [7:0]  exp_big;
    logic [31:0] m_big;
    logic [31:0] m_small;
  } fpa_align_t;

  // stage 2 -> stage 3: raw sum and normalisation shift
  typedef struct packed {
    logic        valid;
    logic        special;
    logic [31:0] special_bits;
    logic        sign;
    logic        zero;
    logic [32:0] m_sum;
    logic [7:0]  exp_big;
    logic [4:0]  lz;
  } fpa_sum_t;
endpackage
`default_nettype wire

[rtl/fpa_align.sv]
// stage 1: special cases, magnitude ordering and significand alignment
`default_nettype none
module fpa_align
  import fpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output fpa_align_t       align_o
);
  fpa_align_t align_d, align_q;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, swap;
  logic [31:0] big, little;
  logic [7:0]  eb, es, d;
  logic [31:0] mb, ms, lost_mask;

  always_comb begin
    a_nan  = (operand_a_i[30:23] == ExpMax) && (operand_a_i[22:0] != '0);
    b_nan  = (operand_b_i[30:23] == ExpMax) && (operand_b_i[22:0] != '0);
    a_inf  = (operand_a_i[30:23] == ExpMax) && (operand_a_i[22:0] == '0);
    b_inf  = (operand_b_i[30:23] == ExpMax) && (operand_b_i[22:0] == '0);
    a_zero = operand_a_i[30:0] == '0;
    b_zero = operand_b_i[30:0] == '0;
    swap   = operand_a_i[30:0] < operand_b_i[30:0];
    big    = swap ? operand_b_i : operand_a_i;
    little = swap ? operand_a_i : operand_b_i;
    eb = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es = (little[30:23] == '0) ? 8'd1 : little[30:23];
    mb = {(big[30:23] != '0), big[22:0], 8'h00};
    ms = {(little[30:23] != '0), little[22:0], 8'h00};
    d  = eb - es;
    lost_mask = '0;
    align_d = '0;
    align_d.valid   = valid_i;
    align_d.sign    = big[31];
    align_d.sub     = operand_a_i[31] ^ operand_b_i[31];
    align_d.exp_big = eb;
    align_d.m_big   = mb;
    // the sticky bit sits in the lowest of the eight guard bits
    if (d >= 8'd32) begin
      align_d.m_small = {31'd0, (ms != '0)};
    end else begin
      lost_mask = (32'd1 << d[4:0]) - 32'd1;
      align_d.m_small = (ms >> d[4:0]) | {31'd0, ((ms & lost_mask) != '0)};
    end
    if (a_nan) begin
      align_d.special = 1'b1; align_d.special_bits = operand_a_i | QuietBit;
    end else if (b_nan) begin
      align_d.special = 1'b1; align_d.special_bits = operand_b_i | QuietBit;
    end else if (a_inf) begin
      align_d.special = 1'b1;
      align_d.special_bits = (b_inf && align_d.sub) ? DefaultNan : operand_a_i;
    end else if (b_inf) begin
      align_d.special = 1'b1; align_d.special_bits = operand_b_i;
    end else if (a_zero && b_zero) begin
      align_d.special = 1'b1; align_d.special_bits = operand_a_i & operand_b_i;
    end else if (a_zero) begin
      align_d.special = 1'b1; align_d.special_bits = operand_b_i;
    end else if (b_zero) begin
      align_d.special = 1'b1; align_d.special_bits = operand_a_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= '0;
    end else begin
      align_q <= align_d;
    end
  end
  assign align_o = align_q;
endmodule
`default_nettype wire

[rtl/fpa_add.sv]
// stage 2: significand add or subtract and leading-zero count
`default_nettype none
module fpa_add
  import fpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  fpa_align_t       align_i,
  output fpa_sum_t         sum_o
);
  fpa_sum_t sum_d, sum_q;
  logic [32:0] m;

  always_comb begin
    m = align_i.sub ? ({1'b0, align_i.m_big} - {1'b0, align_i.m_small})
                    : ({1'b0, align_i.m_big} + {1'b0, align_i.m_small});
    sum_d.valid        = align_i.valid;
    sum_d.special      = align_i.special;
    sum_d.special_bits = align_i.special_bits;
    sum_d.sign         = align_i.sign;
    sum_d.zero         = m == '0;
    sum_d.m_sum        = m;
    sum_d.exp_big      = align_i.exp_big;
    sum_d.lz           = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) sum_d.lz = 5'(31 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end
  assign sum_o = sum_q;
endmodule
`default_nettype wire

[rtl/fpa_round.sv]
// stage 3: normalisation, rounding and result packing
`default_nettype none
module fpa_round
  import fpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  fpa_sum_t         sum_i,
  output logic             valid_o,
  output logic [31:0]      sum_bits_o
);
  logic        valid_q;
  logic [31:0] res_d, res_q, m;
  logic [8:0]  e;
  logic [4:0]  sh;
  logic [24:0] keep;
  logic [7:0]  rem;

  always_comb begin
    e = {1'b0, sum_i.exp_big};
    if (sum_i.m_sum[32]) begin
      m = sum_i.m_sum[32:1] | {31'd0, sum_i.m_sum[0]};
      e = e + 9'd1;
    end else begin
      m = sum_i.m_sum[31:0];
    end
    // shift left, but no further than exponent one
    sh = sum_i.m_sum[32] ? 5'd0 :
         ({4'd0, sum_i.lz} > (e - 9'd1)) ? 5'(e - 9'd1) : sum_i.lz;
    m = m << sh;
    e = e - {4'd0, sh};
    keep = {1'b0, m[31:8]};
    rem  = m[7:0];
    if (rem > 8'h80 || (rem == 8'h80 && keep[0])) keep = keep + 25'd1;
    if (keep[24]) begin
      keep = keep >> 1;
      e = e + 9'd1;
    end
    if (sum_i.special) begin
      res_d = sum_i.special_bits;
    end else if (sum_i.zero) begin
      res_d = '0;
    end else if (e >= 9'd255) begin
      res_d = {sum_i.sign, ExpMax, 23'd0};
    end else begin
      res_d = {sum_i.sign, keep[23] ? e[7:0] : 8'd0, keep[22:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= sum_i.valid;
      res_q   <= res_d;
    end
  end
  assign valid_o    = valid_q;
  assign sum_bits_o = res_q;

`ifndef ASSERT_OFF
  a_valid_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_i.valid |=> valid_o) else $error("result beat lost");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sum_i.valid |=> !valid_o) else $error("result beat invented");
  a_special_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_i.valid && sum_i.special) |=> (sum_bits_o == $past(sum_i.special_bits)))
    else $error("special result altered");
`endif
endmodule
`default_nettype wire

[rtl/fp32_adder.sv]
// binary32 adder top level: three-stage pipeline
//  channel  | ports                                 | handshake
//  operands | start, operand_a_i, operand_b_i       | taken when start && !busy
//  result   | done_o, sum_bits_o                    | one cycle, strobed by done_o
// one item a cycle; a taken beat passes the align, add/count and normalise/round
// register stages in that order before done_o rises
// busy is always low; the pipeline never stalls and the receiver cannot stall
// reset clears every pipeline register
`default_nettype none
module fp32_adder
  import fpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] operand_a_i,
  input  wire logic [31:0] operand_b_i,
  output logic             done_o,
  output logic [31:0]      sum_bits_o
);
  fpa_align_t align;
  fpa_sum_t   sum;

  assign busy = 1'b0;

  fpa_align u_align (.clk_i, .rst_ni, .valid_i(start && !busy),
                     .operand_a_i, .operand_b_i, .align_o(align));
  fpa_add   u_add   (.clk_i, .rst_ni, .align_i(align), .sum_o(sum));
  fpa_round u_round (.clk_i, .rst_ni, .sum_i(sum), .valid_o(done_o), .sum_bits_o);
endmodule
`default_nettype wire

[sim/fp32_adder_test.sv]
// self-checking testbench for the three-stage binary32 adder
`default_nettype none
module fp32_adder_test;
  import fpa_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned CalmTail   = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        done_o;
  logic [31:0] sum_bits_o;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } addend_pair_t;

  addend_pair_t pending_pairs[$];
  logic [31:0]  expected_sums[$];
  int unsigned  send_gap;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  fp32_adder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .done_o     (done_o),
    .sum_bits_o (sum_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bit is_nan32(logic [31:0] x);
    return x[30:23] == ExpMax && x[22:0] != 23'd0;
  endfunction

  function automatic bit is_inf32(logic [31:0] x);
    return x[30:0] == {ExpMax, 23'd0};
  endfunction

  // rounded binary32 sum, nearest-even, subnormals kept
  function automatic logic [31:0] fp32_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] big, lil;
    logic [7:0]  e_big, e_lil;
    logic [63:0] m_big, m_lil, m, keep, rem, lost;
    int          e;
    int unsigned d;
    if (is_nan32(a)) return a | QuietBit;
    if (is_nan32(b)) return b | QuietBit;
    if (is_inf32(a)) begin
      if (is_inf32(b) && (a[31] != b[31])) return DefaultNan;
      return a;
    end
    if (is_inf32(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return a & b;
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      lil = b;
    end else begin
      big = b;
      lil = a;
    end
    e_big = big[30:23];
    e_lil = lil[30:23];
    m_big = {41'd0, big[22:0]};
    m_lil = {41'd0, lil[22:0]};
    if (e_big != 0) m_big[23] = 1'b1; else e_big = 8'd1;
    if (e_lil != 0) m_lil[23] = 1'b1; else e_lil = 8'd1;
    m_big = m_big << 8;
    m_lil = m_lil << 8;
    d = {24'd0, e_big - e_lil};
    if (d >= 63) begin
      m_lil = (m_lil != 0) ? 64'd1 : 64'd0;
    end else if (d > 0) begin
      lost  = m_lil & ((64'd1 << d) - 64'd1);
      m_lil = (m_lil >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    m = (a[31] == b[31]) ? m_big + m_lil : m_big - m_lil;
    if (m == 0) return 32'd0;
    e = int'(e_big);
    if (m >= (64'd1 << 32)) begin
      m = (m >> 1) | (m & 64'd1);
      e++;
    end
    while (m < (64'd1 << 31) && e > 1) begin
      m = m << 1;
      e--;
    end
    keep = m >> 8;
    rem  = m & 64'hFF;
    if (rem > 64'h80 || (rem == 64'h80 && keep[0])) keep++;
    if (keep >= (64'd1 << 24)) begin
      keep = keep >> 1;
      e++;
    end
    if (e >= 255) return {big[31], ExpMax, 23'd0};
    return {big[31], keep[23] ? e[7:0] : 8'd0, keep[22:0]};
  endfunction

  // operands drawn from classes that reach the interesting corners
  function automatic logic [31:0] pick_operand(logic [31:0] near);
    logic [31:0] x;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    x    = $urandom;
    case (kind)
      0, 1, 2: ;
      3, 4: x[30:23] = near[30:23] + 8'($urandom_range(0, 6)) - 8'd3;
      5: begin
        x[30:0] = near[30:0] ^ (31'd1 << $urandom_range(0, 24));
      end
      6: x[30:23] = 8'd0;
      7: x[30:23] = $urandom_range(0, 1) ? ExpMax : 8'd254;
      8: x[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
      default: x[30:23] = 8'($urandom_range(1, 3));
    endcase
    return x;
  endfunction

  // driver: start held while an item is offered
  always @(posedge clk_i or negedge rst_ni) begin
    addend_pair_t pair;
    if (!rst_ni) begin
      start       <= 1'b0;
      operand_a_i <= 32'd0;
      operand_b_i <= 32'd0;
      send_gap    <= 0;
    end else begin
      if (start && !busy) expected_sums.push_back(fp32_sum(operand_a_i, operand_b_i));
      if (start && busy) begin
        // beat not yet taken, hold it
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        start    <= 1'b0;
      end else if (pending_pairs.size() > CalmTail && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 12);
        start    <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        pair = pending_pairs.pop_front();
        start       <= 1'b1;
        operand_a_i <= pair.a;
        operand_b_i <= pair.b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && done_o) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", sum_bits_o);
      end else begin
        want = expected_sums.pop_front();
        if (want !== sum_bits_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sum mismatch: expected %h, got %h", want, sum_bits_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_pair(logic [31:0] a, logic [31:0] b);
    addend_pair_t pair;
    pair.a = a;
    pair.b = b;
    pending_pairs.push_back(pair);
  endtask

  initial begin
    logic [31:0] a;
    rst_ni          = 1'b0;
    // signed zeros and exact cancellation
    add_pair(32'h0000_0000, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h8000_0000);
    add_pair(32'h3F80_0000, 32'hBF80_0000);
    // infinities and quiet/signalling nans, a taking priority
    add_pair(32'h7F80_0000, 32'hFF80_0000);
    add_pair(32'hFF80_0000, 32'hFF80_0000);
    add_pair(32'h7F80_0000, 32'h3F80_0000);
    add_pair(32'h4000_0000, 32'hFF80_0000);
    add_pair(32'h7F80_0001, 32'hFFC0_1234);
    add_pair(32'h3F80_0000, 32'hFF80_0001);
    add_pair(32'h7FFF_FFFF, 32'h7F80_0000);
    // overflow and the largest/smallest magnitudes
    add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    add_pair(32'hFF7F_FFFF, 32'hFF7F_FFFF);
    add_pair(32'h7F7F_FFFF, 32'h7300_0000);
    add_pair(32'h0000_0001, 32'h0000_0001);
    add_pair(32'h007F_FFFF, 32'h0000_0001);
    add_pair(32'h0080_0000, 32'h8000_0001);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // ties to even, sticky and huge exponent gap
    add_pair(32'h3F80_0000, 32'h3380_0000);
    add_pair(32'h3F80_0001, 32'h3380_0000);
    add_pair(32'h3F80_0000, 32'h33C0_0000);
    add_pair(32'h7F00_0000, 32'h0000_0001);
    add_pair(32'h3F80_0000, 32'hB3FF_FFFF);
    for (int i = 0; i < 2000; i++) begin
      a = pick_operand($urandom);
      add_pair(a, pick_operand(a));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() == 0 && !start && expected_sums.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
